// ===== rtl/nwt_pkg.sv =====
package nwt_pkg;

  // Default configuration of the table
  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_COORD_BITS = 20;

  // Corner scale register, unsigned Q2.8
  localparam int         SCALE_W     = 10;
  localparam logic [9:0] SCALE_RESET = 10'd307;

  // Offset = (size * scale + ROUND_BIAS) >> OFF_SHIFT: half size times scale, rounded half up
  localparam int ROUND_BIAS = 256;
  localparam int OFF_SHIFT  = 9;

  // Depth of the command queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/nwt_front.sv =====
module nwt_front
  import nwt_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int IN_W       = ((5 * DEF_COORD_BITS - 2 + 7) / 8) * 8,
  parameter int CMD_W      = REQ_W + 5 * DEF_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [REQ_W-1:0]   s_tuser,
  input  logic [IN_W-1:0]    s_tdata,
  output logic               q_push,
  input  logic               q_full,
  output logic [CMD_W-1:0]   q_wdata
);

  localparam int C      = COORD_BITS;
  localparam int SIZE_W = C - 1;
  localparam int PROD_W = C + SCALE_W;

  logic [SCALE_W-1:0] corner_scale;
  logic [C-1:0]       pos_x;
  logic [C-1:0]       pos_y;
  logic [C-1:0]       pos_z;
  logic [SIZE_W-1:0]  foot_width;
  logic [SIZE_W-1:0]  foot_depth;
  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_z;
  logic [C-1:0]       off_x;
  logic [C-1:0]       off_z;
  op_t                op;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      corner_scale <= cfg_wdata;
    end
  end

  assign pos_x      = s_tdata[0 +: C];
  assign pos_y      = s_tdata[C +: C];
  assign pos_z      = s_tdata[2*C +: C];
  assign foot_width = s_tdata[3*C +: SIZE_W];
  assign foot_depth = s_tdata[3*C+SIZE_W +: SIZE_W];

  // Scaled half sizes; they fit in C bits unsigned
  assign prod_x = PROD_W'(foot_width) * PROD_W'(corner_scale) + PROD_W'(ROUND_BIAS);
  assign prod_z = PROD_W'(foot_depth) * PROD_W'(corner_scale) + PROD_W'(ROUND_BIAS);
  assign off_x  = prod_x[OFF_SHIFT +: C];
  assign off_z  = prod_z[OFF_SHIFT +: C];

  assign op = op_t'(s_tuser);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_wdata  = {off_z, off_x, pos_z, pos_y, pos_x, op};

endmodule

// ===== rtl/nwt_queue.sv =====
module nwt_queue
  import nwt_pkg::*;
#(
  parameter int WIDTH = REQ_W + 5 * DEF_COORD_BITS,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign valid   = (fill != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/nwt_back.sv =====
module nwt_back
  import nwt_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int CMD_W      = REQ_W + 5 * DEF_COORD_BITS,
  parameter int IDX_W      = $clog2(DEF_MAX_POINTS),
  parameter int CNT_W      = $clog2(DEF_MAX_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [CMD_W-1:0]      q_rdata,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output status_t               res_status,
  output logic [IDX_W-1:0]      res_idx,
  output logic [COORD_BITS-1:0] res_x,
  output logic [COORD_BITS-1:0] res_y,
  output logic [COORD_BITS-1:0] res_z,
  output logic [CNT_W-1:0]      res_cnt
);

  localparam int C     = COORD_BITS;
  localparam int SQ_W  = 2 * C + 1;
  localparam int SUM_W = 2 * C + 2;
  localparam logic signed [C+1:0] CMAX = (C+2)'((1 << (C - 1)) - 1);
  localparam logic signed [C+1:0] CMIN = -CMAX - 1;
  localparam logic [CNT_W:0]       MAXP = (CNT_W+1)'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADD  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  function automatic logic [C-1:0] corner(input logic [C-1:0] base, input logic [C-1:0] off,
                                          input logic plus);
    logic signed [C+1:0] sum;
    sum = plus ? $signed({{2{base[C-1]}}, base}) + $signed({2'b00, off})
               : $signed({{2{base[C-1]}}, base}) - $signed({2'b00, off});
    if (sum > CMAX) begin
      return CMAX[C-1:0];
    end else if (sum < CMIN) begin
      return CMIN[C-1:0];
    end
    return sum[C-1:0];
  endfunction

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rd_cnt;
  logic [1:0]       corner_k;

  // current command
  op_t          cur_op;
  logic [C-1:0] cur_x;
  logic [C-1:0] cur_y;
  logic [C-1:0] cur_z;
  logic [C-1:0] cur_ox;
  logic [C-1:0] cur_oz;

  logic [3*C-1:0] mem [MAX_POINTS];
  logic [3*C-1:0] rdata;

  // scan pipeline
  logic               v1, v2, v3;
  logic [IDX_W-1:0]   idx1, idx2, idx3;
  logic [3*C-1:0]     pt2, pt3;
  logic [SQ_W-1:0]    sqx, sqy, sqz;
  logic [SUM_W-1:0]   sum3;
  logic [SUM_W-1:0]   best_d;
  logic [IDX_W-1:0]   best_idx;
  logic [3*C-1:0]     best_pt;

  logic               pop;
  logic               add_full;
  logic               scan_issue;
  logic               scan_done;
  logic               add_last;
  logic signed [C:0]  dx, dy, dz;
  logic signed [2*C+1:0] px2, py2, pz2;
  logic [C-1:0]       cx, cz;

  assign pop        = (state == S_IDLE) && q_valid && !m_tvalid;
  assign q_pop      = pop;
  assign add_full   = ({1'b0, cnt} + (CNT_W+1)'(4)) > MAXP;
  assign scan_issue = (state == S_SCAN) && (rd_cnt != cnt);
  assign scan_done  = (state == S_SCAN) && (rd_cnt == cnt) && !v1 && !v2 && !v3;
  assign add_last   = (state == S_ADD) && (corner_k == 2'd3);

  assign cx = corner(cur_x, cur_ox, corner_k[0]);
  assign cz = corner(cur_z, cur_oz, corner_k[1]);

  assign dx  = $signed({rdata[C-1], rdata[0 +: C]})   - $signed({cur_x[C-1], cur_x});
  assign dy  = $signed({rdata[2*C-1], rdata[C +: C]}) - $signed({cur_y[C-1], cur_y});
  assign dz  = $signed({rdata[3*C-1], rdata[2*C +: C]}) - $signed({cur_z[C-1], cur_z});
  assign px2 = dx * dx;
  assign py2 = dy * dy;
  assign pz2 = dz * dz;

  always_ff @(posedge clk) begin
    if (state == S_ADD) begin
      mem[cnt[IDX_W-1:0]] <= {cz, cur_y, cx};
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rdata <= mem[rd_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      rd_cnt   <= '0;
      corner_k <= '0;
      m_tvalid <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
    end else begin
      v1 <= scan_issue;
      v2 <= v1;
      v3 <= v2;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (op_t'(q_rdata[REQ_W-1:0]))
              OP_CLEAR: begin
                cnt      <= '0;
                m_tvalid <= 1'b1;
              end
              OP_ADD: begin
                if (add_full) begin
                  m_tvalid <= 1'b1;
                end else begin
                  state    <= S_ADD;
                  corner_k <= '0;
                end
              end
              OP_QUERY: begin
                if (cnt == '0) begin
                  m_tvalid <= 1'b1;
                end else begin
                  state  <= S_SCAN;
                  rd_cnt <= '0;
                end
              end
              default: m_tvalid <= 1'b1;
            endcase
          end
        end
        S_ADD: begin
          cnt      <= cnt + 1'b1;
          corner_k <= corner_k + 1'b1;
          if (add_last) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end else if (scan_done) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op <= op_t'(q_rdata[REQ_W-1:0]);
      cur_x  <= q_rdata[REQ_W +: C];
      cur_y  <= q_rdata[REQ_W+C +: C];
      cur_z  <= q_rdata[REQ_W+2*C +: C];
      cur_ox <= q_rdata[REQ_W+3*C +: C];
      cur_oz <= q_rdata[REQ_W+4*C +: C];
    end

    // squares, then sum, then keep the running minimum
    idx1 <= rd_cnt[IDX_W-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    pt2  <= rdata;
    pt3  <= pt2;
    sqx  <= px2[SQ_W-1:0];
    sqy  <= py2[SQ_W-1:0];
    sqz  <= pz2[SQ_W-1:0];
    sum3 <= SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
    if (v3 && (idx3 == '0 || sum3 < best_d)) begin
      best_d   <= sum3;
      best_idx <= idx3;
      best_pt  <= pt3;
    end

    if (pop) begin
      res_idx <= '0;
      res_x   <= '0;
      res_y   <= '0;
      res_z   <= '0;
      res_cnt <= cnt;
      unique case (op_t'(q_rdata[REQ_W-1:0]))
        OP_CLEAR: begin
          res_status <= ST_OK;
          res_cnt    <= '0;
        end
        OP_ADD:   res_status <= add_full ? ST_FULL : ST_OK;
        OP_QUERY: res_status <= (cnt == '0) ? ST_EMPTY : ST_OK;
        default:  res_status <= ST_OK;
      endcase
    end else if (add_last) begin
      res_cnt <= cnt + 1'b1;
    end else if (scan_done && cur_op == OP_QUERY) begin
      res_idx <= best_idx;
      res_x   <= best_pt[0 +: C];
      res_y   <= best_pt[C +: C];
      res_z   <= best_pt[2*C +: C];
    end
  end

endmodule

// ===== rtl/nearest_waypoint_table.sv =====
// Nearest-waypoint table: stores up to MAX_POINTS 3D points (signed Q16.4) and
// answers nearest-point queries by a linear scan of squared distances.
// Input channel s_axis: tuser carries the request kind (clear, add footprint,
// query); tdata carries the position and footprint sizes. Output channel
// m_axis: one result per request, tuser is the status, tdata the nearest
// entry and the point count. cfg_we/cfg_wdata set the corner scale (Q2.8);
// write it only while the block is idle.
// Clear and unknown requests are answered from the idle state; an add
// writes one memory entry per corner; a query reads one memory entry a
// cycle through a four-stage distance pipeline.
// A two-deep request queue sits in front of the executing logic, so requests
// are accepted while a result still waits on m_axis; when m_axis stalls, the
// result register holds and the queue fills, then s_axis_tready drops.
// Reset empties the table and the queue and restores the scale to 307; the
// point memory itself is not cleared, entries above the count are never read.
module nearest_waypoint_table
  import nwt_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS,
  localparam int IDX_W     = $clog2(MAX_POINTS),
  localparam int CNT_W     = $clog2(MAX_POINTS + 1),
  localparam int IN_W      = ((5 * COORD_BITS - 2 + 7) / 8) * 8,
  localparam int OUT_W     = ((IDX_W + 3 * COORD_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // req_type
  input  logic [REQ_W-1:0]   s_axis_tuser,
  // pos_x, pos_y, pos_z, foot_width, foot_depth, zero pad
  input  logic [IN_W-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // status
  output logic [STATUS_W-1:0] m_axis_tuser,
  // nearest_index, near_x, near_y, near_z, point_count, zero pad
  output logic [OUT_W-1:0]   m_axis_tdata
);

  localparam int CMD_W = REQ_W + 5 * COORD_BITS;

  logic                  q_push;
  logic                  q_full;
  logic [CMD_W-1:0]      q_wdata;
  logic                  q_pop;
  logic                  q_valid;
  logic [CMD_W-1:0]      q_rdata;
  status_t               res_status;
  logic [IDX_W-1:0]      res_idx;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic [COORD_BITS-1:0] res_z;
  logic [CNT_W-1:0]      res_cnt;

  // Decode the request and scale the footprint half sizes
  nwt_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tuser   (s_axis_tuser),
    .s_tdata   (s_axis_tdata),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  // Hold decoded requests until the back end is free
  nwt_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // Execute: clear, write corners, or scan for the nearest point
  nwt_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .res_status (res_status),
    .res_idx    (res_idx),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_z      (res_z),
    .res_cnt    (res_cnt)
  );

  // Pack the result, lowest field first
  assign m_axis_tuser = res_status;
  assign m_axis_tdata = OUT_W'({res_cnt, res_z, res_y, res_x, res_idx});

endmodule
